@@ hw/rtl/prc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package prc_pkg;

  // Extra fraction bits carried by the coordinate datapath.
  localparam int GUARD = 16;

  // Most CORDIC stages the arctangent table supports.
  localparam int MAX_STAGES = 24;

  // Angle accumulator width: Q30 radians with room for +-pi plus the table sum.
  localparam int ZW = 34;

  // Reciprocal of the CORDIC gain for an unbounded stage count, Q30.
  localparam logic [29:0] GAIN_Q30 = 30'd652032874;

  localparam logic signed [ZW-1:0] PI_Q30      = 34'sd3373259426;
  localparam logic signed [ZW-1:0] HALF_PI_Q30 = 34'sd1686629713;

  // Output angle limit, Q3.13.
  localparam logic signed [15:0] PI_Q13 = 16'sd25736;

  // atan(2^-i) in Q30, rounded to nearest.
  localparam logic [29:0] ATAN_Q30 [MAX_STAGES] = '{
    30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159,
    30'd67021687,  30'd33543516,  30'd16775851,  30'd8388437,
    30'd4194283,   30'd2097149,   30'd1048576,   30'd524288,
    30'd262144,    30'd131072,    30'd65536,     30'd32768,
    30'd16384,     30'd8192,      30'd4096,      30'd2048,
    30'd1024,      30'd512,       30'd256,       30'd128
  };

endpackage

`default_nettype wire

@@ hw/rtl/polar_rect_converter.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Polar/rectangular converter built on a fully unrolled CORDIC. With in_tuser
// low, a request carries a Q8.8 magnitude and a Q3.13 angle in radians and the
// result gives x and y; with in_tuser high it carries x and y and the result
// gives the magnitude and the full-quadrant angle. Fields that do not belong to
// the chosen direction read as zero. A new request is taken every cycle while
// the output is not held; each one passes through a register for the gain
// multipliers, one to round and fold the start vector, one register per CORDIC
// iteration, and the output register. When the output is held by a low
// out_tready the whole pipeline holds, and in_tready drops only while a result
// waits in the output register and is not taken in that cycle.
module polar_rect_converter #(
  parameter int ITERATIONS  = 16,
  parameter int COORD_WIDTH = 16
) (
  input  wire logic clk,
  input  wire logic rst_n,

  input  wire logic                                           in_tvalid,
  output      logic                                           in_tready,
  // in_x, in_y, in_magnitude, in_angle from the lowest bit up, zero padded
  input  wire logic [((3*COORD_WIDTH+16+7)/8)*8-1:0]          in_tdata,
  // mode
  input  wire logic [0:0]                                     in_tuser,

  output      logic                                           out_tvalid,
  input  wire logic                                           out_tready,
  // out_x, out_y, out_magnitude, out_angle from the lowest bit up, zero padded
  output      logic [((3*COORD_WIDTH+18+7)/8)*8-1:0]          out_tdata
);

  localparam int CW    = COORD_WIDTH;
  localparam int NST   = (ITERATIONS > prc_pkg::MAX_STAGES) ? prc_pkg::MAX_STAGES : ITERATIONS;
  localparam int ZW    = prc_pkg::ZW;
  localparam int GD    = prc_pkg::GUARD;
  localparam int PW    = CW + 30;          // gain product
  localparam int SW    = CW + GD;          // scaled start magnitude
  localparam int XW    = CW + GD + 3;      // signed coordinate datapath
  localparam int RW    = XW - GD;          // rounded coordinate
  localparam int OUT_W = ((3*CW+18+7)/8)*8;

  logic en;

  // Input field split.
  logic        [CW-1:0] in_x_w;
  logic        [CW-1:0] in_y_w;
  logic        [CW-1:0] in_mag_w;
  logic signed [15:0]   in_ang_w;
  logic                 mode_w;

  assign in_x_w   = in_tdata[CW-1:0];
  assign in_y_w   = in_tdata[2*CW-1:CW];
  assign in_mag_w = in_tdata[3*CW-1:2*CW];
  assign in_ang_w = in_tdata[3*CW+15:3*CW];
  assign mode_w   = in_tuser[0];

  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  // ---------------------------------------------------------------------------
  // Stage 0: gain multiply and start angle selection.
  // ---------------------------------------------------------------------------
  logic        [CW-1:0] abs_x_w;
  logic        [CW-1:0] abs_y_w;
  logic        [CW-1:0] op_a_w;
  logic        [CW-1:0] op_b_w;
  logic signed [ZW-1:0] za_w;
  logic signed [ZW-1:0] z0_nxt;
  logic                 neg_x_nxt;
  logic                 neg_y_nxt;
  logic                 zero_nxt;

  logic                 v0_r;
  logic                 mode0_r;
  logic                 zero0_r;
  logic                 neg_x0_r;
  logic                 neg_y0_r;
  logic        [PW-1:0] prod_a_r;
  logic        [PW-1:0] prod_b_r;
  logic signed [ZW-1:0] z0_r;

  assign abs_x_w = in_x_w[CW-1] ? (~in_x_w + 1'b1) : in_x_w;
  assign abs_y_w = in_y_w[CW-1] ? (~in_y_w + 1'b1) : in_y_w;
  assign op_a_w  = mode_w ? abs_x_w : in_mag_w;
  assign op_b_w  = mode_w ? abs_y_w : '0;
  assign za_w    = {{(ZW-33){in_ang_w[15]}}, in_ang_w, 17'd0};

  always_comb begin
    z0_nxt    = '0;
    neg_x_nxt = 1'b0;
    neg_y_nxt = 1'b0;
    zero_nxt  = 1'b0;
    if (mode_w) begin
      // Left half plane: turn the vector by pi and start the angle there.
      neg_y_nxt = in_y_w[CW-1] ^ in_x_w[CW-1];
      zero_nxt  = (in_x_w == '0) && (in_y_w == '0);
      if (in_x_w[CW-1]) begin
        z0_nxt = in_y_w[CW-1] ? -prc_pkg::PI_Q30 : prc_pkg::PI_Q30;
      end
    end else begin
      priority if (za_w > prc_pkg::HALF_PI_Q30) begin
        neg_x_nxt = 1'b1;
        z0_nxt    = za_w - prc_pkg::PI_Q30;
      end else if (za_w < -prc_pkg::HALF_PI_Q30) begin
        neg_x_nxt = 1'b1;
        z0_nxt    = za_w + prc_pkg::PI_Q30;
      end else begin
        z0_nxt = za_w;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mode0_r  <= mode_w;
      zero0_r  <= zero_nxt;
      neg_x0_r <= neg_x_nxt;
      neg_y0_r <= neg_y_nxt;
      prod_a_r <= PW'(op_a_w) * PW'(prc_pkg::GAIN_Q30);
      prod_b_r <= PW'(op_b_w) * PW'(prc_pkg::GAIN_Q30);
      z0_r     <= z0_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: round the scaled start vector and apply its signs.
  // Entry 0 of the stage arrays is this register; entry i+1 follows iteration i.
  // ---------------------------------------------------------------------------
  logic                 v_r    [NST+1];
  logic                 mode_r [NST+1];
  logic                 zero_r [NST+1];
  logic signed [XW-1:0] x_r    [NST+1];
  logic signed [XW-1:0] y_r    [NST+1];
  logic signed [ZW-1:0] z_r    [NST+1];

  logic        [PW-1:0] rnd_a_w;
  logic        [PW-1:0] rnd_b_w;
  logic signed [XW-1:0] sa_w;
  logic signed [XW-1:0] sb_w;

  assign rnd_a_w = prod_a_r + PW'(1 << (29 - GD));
  assign rnd_b_w = prod_b_r + PW'(1 << (29 - GD));
  assign sa_w    = XW'(rnd_a_w[SW+30-GD-1:30-GD]);
  assign sb_w    = XW'(rnd_b_w[SW+30-GD-1:30-GD]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= v0_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mode_r[0] <= mode0_r;
      zero_r[0] <= zero0_r;
      x_r[0]    <= neg_x0_r ? -sa_w : sa_w;
      y_r[0]    <= neg_y0_r ? -sb_w : sb_w;
      z_r[0]    <= z0_r;
    end
  end

  // ---------------------------------------------------------------------------
  // CORDIC iterations, one register stage each.
  // ---------------------------------------------------------------------------
  for (genvar i = 0; i < NST; i++) begin : g_iter
    logic signed [XW-1:0] dx_w;
    logic signed [XW-1:0] dy_w;
    logic signed [ZW-1:0] at_w;
    logic                 fwd_w;
    logic signed [XW-1:0] x_nxt;
    logic signed [XW-1:0] y_nxt;
    logic signed [ZW-1:0] z_nxt;

    assign dx_w = y_r[i] >>> i;
    assign dy_w = x_r[i] >>> i;
    assign at_w = ZW'(prc_pkg::ATAN_Q30[i]);
    // Rotation steers on the residual angle, vectoring on the sign of y.
    assign fwd_w = mode_r[i] ? y_r[i][XW-1] : !z_r[i][ZW-1];

    always_comb begin
      if (fwd_w) begin
        x_nxt = x_r[i] - dx_w;
        y_nxt = y_r[i] + dy_w;
        z_nxt = z_r[i] - at_w;
      end else begin
        x_nxt = x_r[i] + dx_w;
        y_nxt = y_r[i] - dy_w;
        z_nxt = z_r[i] + at_w;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i+1] <= 1'b0;
      end else if (en) begin
        v_r[i+1] <= v_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        mode_r[i+1] <= mode_r[i];
        zero_r[i+1] <= zero_r[i];
        x_r[i+1]    <= x_nxt;
        y_r[i+1]    <= y_nxt;
        z_r[i+1]    <= z_nxt;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output stage: round, saturate and select the fields of the direction.
  // ---------------------------------------------------------------------------
  logic signed [XW-1:0] xs_w;
  logic signed [XW-1:0] ys_w;
  logic signed [ZW-1:0] zs_w;
  logic signed [RW-1:0] xr_w;
  logic signed [RW-1:0] yr_w;
  logic signed [16:0]   ar_w;
  logic signed [RW-1:0] cmax_w;
  logic signed [CW:0]   ox_w;
  logic signed [CW:0]   oy_w;
  logic        [CW-1:0] omag_w;
  logic signed [15:0]   oang_w;

  logic signed [CW:0]   out_x_nxt;
  logic signed [CW:0]   out_y_nxt;
  logic        [CW-1:0] out_mag_nxt;
  logic signed [15:0]   out_ang_nxt;

  logic                 out_valid_r;
  logic signed [CW:0]   out_x_r;
  logic signed [CW:0]   out_y_r;
  logic        [CW-1:0] out_mag_r;
  logic signed [15:0]   out_ang_r;

  assign cmax_w = RW'({CW{1'b1}});
  assign xs_w   = x_r[NST] + XW'(1 << (GD - 1));
  assign ys_w   = y_r[NST] + XW'(1 << (GD - 1));
  assign zs_w   = z_r[NST] + ZW'(1 << 16);
  assign xr_w   = xs_w[XW-1:GD];
  assign yr_w   = ys_w[XW-1:GD];
  assign ar_w   = zs_w[ZW-1:17];

  always_comb begin
    priority if (xr_w > cmax_w) begin
      ox_w = (CW+1)'(cmax_w);
    end else if (xr_w < -cmax_w) begin
      ox_w = (CW+1)'(-cmax_w);
    end else begin
      ox_w = xr_w[CW:0];
    end

    priority if (yr_w > cmax_w) begin
      oy_w = (CW+1)'(cmax_w);
    end else if (yr_w < -cmax_w) begin
      oy_w = (CW+1)'(-cmax_w);
    end else begin
      oy_w = yr_w[CW:0];
    end

    priority if (xr_w[RW-1]) begin
      omag_w = '0;
    end else if (xr_w > cmax_w) begin
      omag_w = {CW{1'b1}};
    end else begin
      omag_w = xr_w[CW-1:0];
    end

    priority if (ar_w > 17'(prc_pkg::PI_Q13)) begin
      oang_w = prc_pkg::PI_Q13;
    end else if (ar_w < -17'(prc_pkg::PI_Q13)) begin
      oang_w = -prc_pkg::PI_Q13;
    end else begin
      oang_w = ar_w[15:0];
    end

    out_x_nxt   = '0;
    out_y_nxt   = '0;
    out_mag_nxt = '0;
    out_ang_nxt = '0;
    if (!mode_r[NST]) begin
      out_x_nxt = ox_w;
      out_y_nxt = oy_w;
    end else if (!zero_r[NST]) begin
      out_mag_nxt = omag_w;
      out_ang_nxt = oang_w;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= v_r[NST];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_x_r   <= out_x_nxt;
      out_y_r   <= out_y_nxt;
      out_mag_r <= out_mag_nxt;
      out_ang_r <= out_ang_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'({out_ang_r, out_mag_r, out_y_r, out_x_r});

endmodule

`default_nettype wire

@@ hw/rtl/prc_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module prc_checker #(
  parameter int COORD_WIDTH = 16
) (
  input wire logic                                  clk,
  input wire logic                                  rst_n,
  input wire logic                                  in_tready,
  input wire logic                                  out_tvalid,
  input wire logic                                  out_tready,
  input wire logic [((3*COORD_WIDTH+18+7)/8)*8-1:0] out_tdata
);

  localparam int CW = COORD_WIDTH;

  logic        [CW:0]   chk_x;
  logic        [CW:0]   chk_y;
  logic        [CW-1:0] chk_mag;
  logic signed [15:0]   chk_ang;

  assign chk_x   = out_tdata[CW:0];
  assign chk_y   = out_tdata[2*CW+1:CW+1];
  assign chk_mag = out_tdata[3*CW+1:2*CW+2];
  assign chk_ang = out_tdata[3*CW+17:3*CW+2];

  // A held result keeps its payload until it is taken.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // A result carries either rectangular or polar fields, never both.
  a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((chk_x == '0) && (chk_y == '0)) || ((chk_mag == '0) && (chk_ang == '0)))
    else $error("result mixes both directions");

  // The angle never leaves the +-pi range.
  a_ang_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (chk_ang <= prc_pkg::PI_Q13) && (chk_ang >= -prc_pkg::PI_Q13))
    else $error("angle out of range");

  // The input side is refused only while a result waits untaken.
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled without back pressure");

  // Nothing comes out in the cycle after reset.
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind polar_rect_converter prc_checker #(.COORD_WIDTH(COORD_WIDTH)) u_prc_checker (.*);

`default_nettype wire

@@ bench/tb_polar_rect_converter.sv @@
`timescale 1ns / 1ps

module tb_polar_rect_converter;

  localparam int COORD_W  = 16;
  localparam int STAGES   = 16;
  localparam int PIPE_LAT = STAGES + 3;
  localparam int IN_W     = ((3*COORD_W+16+7)/8)*8;
  localparam int OUT_W    = ((3*COORD_W+18+7)/8)*8;
  localparam int HOLD_CYCLES = 400;

  localparam logic MODE_TO_RECT  = 1'b0;
  localparam logic MODE_TO_POLAR = 1'b1;

  localparam longint GAIN_Z    = 64'sd652032874;
  localparam longint PI_Z      = 64'sd3373259426;
  localparam longint HALF_PI_Z = 64'sd1686629713;
  localparam longint ANGLE_LIM = 64'sd25736;
  localparam longint COORD_MAX = 64'sd65535;

  // atan(2^-i) scaled by 2^30.
  localparam longint ATAN_Z [STAGES] = '{
    64'sd843314857, 64'sd497837829, 64'sd263043837, 64'sd133525159,
    64'sd67021687,  64'sd33543516,  64'sd16775851,  64'sd8388437,
    64'sd4194283,   64'sd2097149,   64'sd1048576,   64'sd524288,
    64'sd262144,    64'sd131072,    64'sd65536,     64'sd32768
  };

  typedef struct packed {
    logic               mode;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic        [15:0] mag;
    logic signed [15:0] ang;
  } conv_req_t;

  typedef struct packed {
    logic signed [16:0] x;
    logic signed [16:0] y;
    logic        [15:0] mag;
    logic signed [15:0] ang;
  } conv_res_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  // in_x, in_y, in_magnitude, in_angle from the lowest bit up
  logic [IN_W-1:0]  in_tdata = '0;
  // mode
  logic [0:0]       in_tuser = '0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  // out_x, out_y, out_magnitude, out_angle from the lowest bit up, zero padded
  logic [OUT_W-1:0] out_tdata;

  conv_req_t pending_reqs [$];
  conv_res_t expected_res [$];
  conv_req_t cur_req;

  int send_idle = 33;
  int recv_idle = 88;
  int phase = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int n_rect = 0;
  int n_polar = 0;
  int n_checked = 0;
  int n_errors = 0;

  polar_rect_converter #(
    .ITERATIONS (STAGES),
    .COORD_WIDTH(COORD_W)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic longint gain_comp(longint v);
    longint a;
    a = (v < 0) ? -v : v;
    a = (a * GAIN_Z + 64'sd8192) >>> 14;
    return (v < 0) ? -a : a;
  endfunction

  function automatic longint round_guard(longint v);
    return (v + 64'sd32768) >>> 16;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Fixed-point CORDIC: rotation for the rectangular direction, vectoring for
  // the polar one. Coordinates carry 16 guard bits, the angle is Q30.
  function automatic conv_res_t convert(conv_req_t r);
    conv_res_t res;
    longint x, y, z, dx, dy;
    res = '0;
    if (r.mode == MODE_TO_RECT) begin
      z = longint'($signed(r.ang)) * 64'sd131072;
      x = gain_comp(longint'(r.mag));
      y = 0;
      // Fold angles beyond a right angle by flipping the start vector.
      if (z > HALF_PI_Z) begin
        x = -x;
        z = z - PI_Z;
      end else if (z < -HALF_PI_Z) begin
        x = -x;
        z = z + PI_Z;
      end
      for (int i = 0; i < STAGES; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x = x - dx;
          y = y + dy;
          z = z - ATAN_Z[i];
        end else begin
          x = x + dx;
          y = y - dy;
          z = z + ATAN_Z[i];
        end
      end
      res.x = 17'(clip(round_guard(x), -COORD_MAX, COORD_MAX));
      res.y = 17'(clip(round_guard(y), -COORD_MAX, COORD_MAX));
    end else if (r.x != 0 || r.y != 0) begin
      x = gain_comp(longint'($signed(r.x)));
      y = gain_comp(longint'($signed(r.y)));
      z = 0;
      // Left half plane: turn the vector round and start from +pi or -pi.
      if ($signed(r.x) < 0) begin
        x = -x;
        y = -y;
        z = ($signed(r.y) >= 0) ? PI_Z : -PI_Z;
      end
      for (int i = 0; i < STAGES; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (y < 0) begin
          x = x - dx;
          y = y + dy;
          z = z - ATAN_Z[i];
        end else begin
          x = x + dx;
          y = y - dy;
          z = z + ATAN_Z[i];
        end
      end
      res.mag = 16'(clip(round_guard(x), 0, COORD_MAX));
      res.ang = 16'(clip((z + 64'sd65536) >>> 17, -ANGLE_LIM, ANGLE_LIM));
    end
    return res;
  endfunction

  // The unused fields of each direction get random content.
  task automatic add_rect(int mag, int ang);
    conv_req_t r;
    r.mode = MODE_TO_RECT;
    r.x    = 16'($urandom);
    r.y    = 16'($urandom);
    r.mag  = 16'(mag);
    r.ang  = 16'(ang);
    pending_reqs.push_back(r);
  endtask

  task automatic add_polar(int x, int y);
    conv_req_t r;
    r.mode = MODE_TO_POLAR;
    r.x    = 16'(x);
    r.y    = 16'(y);
    r.mag  = 16'($urandom);
    r.ang  = 16'($urandom);
    pending_reqs.push_back(r);
  endtask

  task automatic add_random(int count);
    int sel;
    for (int k = 0; k < count; k++) begin
      sel = $urandom_range(15);
      if ($urandom_range(1) == 0) begin
        if (sel == 0) begin
          add_rect($urandom_range(65535), $urandom_range(65535));
        end else if (sel < 3) begin
          add_rect($urandom_range(46341), $urandom_range(65535));
        end else begin
          add_rect($urandom_range(46341), int'($urandom_range(51472)) - 25736);
        end
      end else begin
        if (sel == 0) begin
          add_polar(int'($urandom_range(8)) - 4, int'($urandom_range(8)) - 4);
        end else if (sel == 1) begin
          add_polar(0, $urandom_range(65535));
        end else if (sel == 2) begin
          add_polar($urandom_range(65535), 0);
        end else begin
          add_polar($urandom_range(65535), $urandom_range(65535));
        end
      end
    end
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || in_tvalid || expected_res.size() != 0)
      @(posedge clk);
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch on result %0d at %0t: %s is %0d, expected %0d",
             n_checked, $time, what, got, want);
    n_errors++;
  endtask

  // Request driver: a new request is offered only once the previous one has
  // been taken, and its expected result is queued at the accepting edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        expected_res.push_back(convert(cur_req));
        if (cur_req.mode == MODE_TO_RECT) n_rect++;
        else n_polar++;
      end
      if (!in_tvalid || in_tready) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle) begin
          cur_req = pending_reqs.pop_front();
          in_tdata  <= {cur_req.ang, cur_req.mag, cur_req.y, cur_req.x};
          in_tuser  <= cur_req.mode;
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result side back-pressure, with one long stall in the last phase so the
  // pipeline fills and the input side has to stop.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (phase == 2 && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk) begin : result_check
    conv_res_t got;
    conv_res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.x   = out_tdata[16:0];
      got.y   = out_tdata[33:17];
      got.mag = out_tdata[49:34];
      got.ang = out_tdata[65:50];
      if (expected_res.size() == 0) begin
        report_mismatch("unexpected result, out_x", got.x, 0);
      end else begin
        want = expected_res.pop_front();
        if (got.x !== want.x) report_mismatch("out_x", got.x, want.x);
        if (got.y !== want.y) report_mismatch("out_y", got.y, want.y);
        if (got.mag !== want.mag) report_mismatch("out_magnitude", got.mag, want.mag);
        if (got.ang !== want.ang) report_mismatch("out_angle", got.ang, want.ang);
        n_checked++;
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Magnitude and angle extremes, the fold points just around +-pi/2 and
    // angles beyond +-pi.
    add_rect(0, 0);
    add_rect(46341, 0);
    add_rect(46341, 25736);
    add_rect(46341, -25736);
    add_rect(46341, 12868);
    add_rect(46341, -12868);
    add_rect(46341, 12867);
    add_rect(65535, 0);
    add_rect(65535, 6434);
    add_rect(256, 32767);
    add_rect(256, -32768);
    // Origin, the axes, three corners and vectors close to the negative x axis.
    add_polar(0, 0);
    add_polar(32767, 0);
    add_polar(-32768, 0);
    add_polar(0, 32767);
    add_polar(0, -32768);
    add_polar(-32768, -32768);
    add_polar(32767, 32767);
    add_polar(-32768, 32767);
    add_polar(-256, 0);
    add_polar(-256, -1);
    add_polar(1, 1);
    add_polar(-1, -1);
    add_random(270);
    wait_drained();

    phase = 1;
    send_idle = 88;
    recv_idle = 33;
    add_random(280);
    wait_drained();

    phase = 2;
    send_idle = 0;
    recv_idle = 0;
    add_random(300);
    wait_drained();

    repeat (2*PIPE_LAT) @(posedge clk);
    $display("Converted %0d polar-to-rectangular and %0d rectangular-to-polar requests,",
             n_rect, n_polar);
    $display("%0d results compared under mixed idling and a %0d-cycle output stall.",
             n_checked, HOLD_CYCLES);
    if (n_errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("timeout with %0d results still expected", expected_res.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
